// File: rtl/gbp_pkg.sv
// gbp_pkg: shared sizes, beat and entry types and small helpers for the
// gshare / btb next-pc predictor. Depends on nothing; used by every rtl file but gbp_ram.
`default_nettype none

package gbp_pkg;

   // sizes
   localparam int BTB_INDEX_BITS = 10;
   localparam int HISTORY_BITS   = 8;
   localparam int ADDR_BITS      = 64;
   localparam int CTR_BITS       = 2;
   localparam int BTB_DEPTH      = 1 << BTB_INDEX_BITS;
   localparam int PHT_DEPTH      = 1 << HISTORY_BITS;
   localparam int TAG_BITS       = ADDR_BITS - BTB_INDEX_BITS;
   localparam int CLEAR_BITS     = (BTB_INDEX_BITS > HISTORY_BITS) ?
                                   BTB_INDEX_BITS : HISTORY_BITS;

   typedef logic [ADDR_BITS-1:0]      addr_type;
   typedef logic [BTB_INDEX_BITS-1:0] btb_index_type;
   typedef logic [HISTORY_BITS-1:0]   pht_index_type;
   typedef logic [HISTORY_BITS-1:0]   history_type;
   typedef logic [TAG_BITS-1:0]       tag_type;
   typedef logic [CTR_BITS-1:0]       ctr_type;
   typedef logic [CLEAR_BITS-1:0]     clear_count_type;

   // request codes
   localparam logic REQ_PREDICT = 1'b0;
   localparam logic REQ_UPDATE  = 1'b1;

   // counter constants
   localparam ctr_type CTR_ZERO      = 2'b00;
   localparam ctr_type CTR_STEP      = 2'b01;
   localparam ctr_type CTR_TAKEN_MIN = 2'b10;
   localparam ctr_type CTR_MAX       = 2'b11;

   localparam addr_type PC_STEP = 64'd4;

   // input beat
   typedef struct packed {
      logic     req_type;
      addr_type pc;
      logic     entry_valid;
      logic     is_conditional;
      addr_type resolved_target;
      logic     was_taken;
      logic     is_indirect;
   } req_beat_type;

   // result beat
   typedef struct packed {
      logic     btb_hit;
      logic     pred_taken;
      addr_type next_pc;
   } rsp_beat_type;

   // one btb entry as stored in its ram
   typedef struct packed {
      logic     valid;
      tag_type  tag;
      logic     is_conditional;
      logic     is_indirect;
      addr_type target;
   } btb_entry_type;

   // btb write port
   typedef struct packed {
      logic          en;
      btb_index_type index;
      btb_entry_type entry;
   } btb_write_type;

   // pht training request from the pipeline
   typedef struct packed {
      logic en;
      logic taken;
   } pht_train_type;

   // clearing sweep after reset
   typedef struct packed {
      logic            active;
      clear_count_type count;
   } clear_type;

   function automatic btb_index_type btb_index_of(input addr_type pc);
      return pc[BTB_INDEX_BITS+1:2];
   endfunction

   function automatic tag_type tag_of(input addr_type pc);
      return {pc[ADDR_BITS-1:BTB_INDEX_BITS+2], pc[1:0]};
   endfunction

   function automatic pht_index_type pht_index_of(input addr_type pc,
                                                  input history_type hist);
      return pc[HISTORY_BITS+1:2] ^ hist;
   endfunction

   // saturating 2-bit counter step
   function automatic ctr_type ctr_train(input ctr_type c, input logic taken);
      ctr_type r;
      r = c;
      if (taken) begin
         if (c != CTR_MAX) r = c + CTR_STEP;
      end else begin
         if (c != CTR_ZERO) r = c - CTR_STEP;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/gshare_btb_branch_predictor.sv
// gshare_btb_branch_predictor: next-pc predictor top level, one input stage
// and one result register around the btb and pht. Depends on gbp_pkg,
// gbp_btb and gbp_pht.
//
// Usage:
//  - req channel (req_valid / req_stall / req_data) carries predict and update
//    beats; rsp channel (rsp_valid / rsp_stall / rsp_data) carries one result
//    beat per predict request, none per update.
//  - a beat accepted into the input stage waits there while the btb and pht
//    rams return its entries, then a predict result is registered in the
//    result register.
//  - throughput is one beat per cycle, predicts and updates in any mix, while
//    rsp_stall holds no predict back; a ram write is forwarded to the next beat.
//  - after reset the block sweeps the btb valid bits and the pattern counters
//    to zero, one entry a cycle, over 2^max(BTB_INDEX_BITS, HISTORY_BITS)
//    indexes (1024 by default); req_stall is high for that whole sweep.
//  - while rsp_stall holds a result back, a predict in the input stage waits
//    and req_stall rises; an update in the input stage still completes, and
//    any beat queued behind a waiting predict waits with it, in order.
`default_nettype none

module gshare_btb_branch_predictor (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire gbp_pkg::req_beat_type req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      gbp_pkg::rsp_beat_type rsp_data
);
   import gbp_pkg::*;

   clear_type     clear_ff;
   clear_type     clear_in;
   logic          s1_valid_ff;
   logic          s1_valid_in;
   req_beat_type  s1_beat_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_beat_type  rsp_data_ff;
   rsp_beat_type  rsp_data_in;

   logic          out_free;
   logic          s1_is_predict;
   logic          s1_advance;
   logic          s1_hold;
   logic          req_accept;
   addr_type      rd_pc;
   addr_type      s1_seq_pc;
   btb_entry_type s1_entry;
   logic          s1_hit;
   ctr_type       s1_ctr;
   btb_write_type btb_wr;
   pht_train_type pht_train;

   // pipeline control
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign s1_is_predict = (s1_beat_ff.req_type == REQ_PREDICT);
   assign s1_advance    = s1_valid_ff && (!s1_is_predict || out_free);
   assign s1_hold       = s1_valid_ff && !s1_advance;
   assign req_stall     = clear_ff.active || s1_hold;
   assign req_accept    = req_valid && !req_stall;
   assign s1_valid_in   = req_accept || s1_hold;
   assign rd_pc         = s1_hold ? s1_beat_ff.pc : req_data.pc;

   // clearing sweep
   always_comb begin
      clear_in = clear_ff;
      if (clear_ff.active) begin
         clear_in.count = clear_ff.count + 1'b1;
         if (&clear_ff.count) clear_in.active = 1'b0;
      end
   end

   gbp_btb u_btb (
      .clock   (clock),
      .reset   (reset),
      .rd_index(btb_index_of(rd_pc)),
      .s1_pc   (s1_beat_ff.pc),
      .wr      (btb_wr),
      .s1_entry(s1_entry),
      .s1_hit  (s1_hit)
   );

   gbp_pht u_pht (
      .clock (clock),
      .reset (reset),
      .rd_pc (rd_pc),
      .s1_pc (s1_beat_ff.pc),
      .train (pht_train),
      .clear (clear_ff),
      .s1_ctr(s1_ctr)
   );

   // btb allocation on an update that misses, or the clearing sweep
   always_comb begin
      if (clear_ff.active) begin
         btb_wr.en    = 1'b1;
         btb_wr.index = clear_ff.count[BTB_INDEX_BITS-1:0];
         btb_wr.entry = '0;
      end else begin
         btb_wr.en                   = s1_advance && !s1_is_predict && !s1_hit;
         btb_wr.index                = btb_index_of(s1_beat_ff.pc);
         btb_wr.entry.valid          = s1_beat_ff.entry_valid;
         btb_wr.entry.tag            = tag_of(s1_beat_ff.pc);
         btb_wr.entry.is_conditional = s1_beat_ff.is_conditional;
         btb_wr.entry.is_indirect    = s1_beat_ff.is_indirect;
         btb_wr.entry.target         = s1_beat_ff.resolved_target;
      end
   end

   // counter and history training on a conditional update
   assign pht_train.en    = s1_advance && !s1_is_predict && s1_beat_ff.is_conditional;
   assign pht_train.taken = s1_beat_ff.was_taken;

   // prediction
   assign s1_seq_pc = s1_beat_ff.pc + PC_STEP;

   always_comb begin
      rsp_data_in.btb_hit    = s1_hit;
      rsp_data_in.pred_taken = 1'b0;
      rsp_data_in.next_pc    = s1_seq_pc;
      if (s1_hit) begin
         if (s1_entry.is_indirect) begin
            rsp_data_in.pred_taken = 1'b1;
         end else if (!s1_entry.is_conditional || (s1_ctr >= CTR_TAKEN_MIN)) begin
            rsp_data_in.pred_taken = 1'b1;
            rsp_data_in.next_pc    = s1_entry.target;
         end
      end
   end

   assign rsp_valid_in = (s1_advance && s1_is_predict) || (rsp_valid_ff && rsp_stall);

   // state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff.active <= 1'b1;
         clear_ff.count  <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_accept) begin
         s1_beat_ff <= req_data;
      end
      if (s1_advance && s1_is_predict) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/gbp_ram.sv
// gbp_ram: generic single write port, single read port ram with registered
// read data (old data on a same-address read and write). No dependencies.
`default_nettype none

module gbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/gbp_btb.sv
// gbp_btb: branch target buffer ram with write forwarding and hit compare.
// Depends on gbp_pkg and gbp_ram.
`default_nettype none

module gbp_btb (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire gbp_pkg::btb_index_type rd_index,
   input  wire gbp_pkg::addr_type      s1_pc,
   input  wire gbp_pkg::btb_write_type wr,
   output      gbp_pkg::btb_entry_type s1_entry,
   output      logic                   s1_hit
);
   import gbp_pkg::*;

   btb_entry_type ram_rd_data;
   logic          fwd_valid_ff;
   btb_index_type fwd_index_ff;
   btb_entry_type fwd_entry_ff;

   gbp_ram #(
      .WIDTH($bits(btb_entry_type)),
      .DEPTH(BTB_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr.en),
      .wr_addr(wr.index),
      .wr_data(wr.entry),
      .rd_addr(rd_index),
      .rd_data(ram_rd_data)
   );

   // last write, for a read issued in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= wr.en;
      end
      fwd_index_ff <= wr.index;
      fwd_entry_ff <= wr.entry;
   end

   // forwarded entry and hit
   always_comb begin
      if (fwd_valid_ff && (fwd_index_ff == btb_index_of(s1_pc))) begin
         s1_entry = fwd_entry_ff;
      end else begin
         s1_entry = ram_rd_data;
      end
      s1_hit = s1_entry.valid && (s1_entry.tag == tag_of(s1_pc));
   end

endmodule

`default_nettype wire

// File: rtl/gbp_pht.sv
// gbp_pht: gshare pattern history table, global history and counter training.
// Depends on gbp_pkg and gbp_ram.
`default_nettype none

module gbp_pht (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire gbp_pkg::addr_type      rd_pc,
   input  wire gbp_pkg::addr_type      s1_pc,
   input  wire gbp_pkg::pht_train_type train,
   input  wire gbp_pkg::clear_type     clear,
   output      gbp_pkg::ctr_type       s1_ctr
);
   import gbp_pkg::*;

   history_type   ghr_ff;
   history_type   ghr_in;
   pht_index_type s1_index;
   pht_index_type wr_index;
   ctr_type       wr_ctr;
   logic          wr_en;
   ctr_type       ram_rd_data;
   logic          fwd_valid_ff;
   pht_index_type fwd_index_ff;
   ctr_type       fwd_ctr_ff;

   // history after this cycle's training, so the next read sees it
   always_comb begin
      if (train.en) begin
         ghr_in = {ghr_ff[HISTORY_BITS-2:0], train.taken};
      end else begin
         ghr_in = ghr_ff;
      end
   end

   assign s1_index = pht_index_of(s1_pc, ghr_ff);

   // forwarded counter of the item in the stage
   always_comb begin
      if (fwd_valid_ff && (fwd_index_ff == s1_index)) begin
         s1_ctr = fwd_ctr_ff;
      end else begin
         s1_ctr = ram_rd_data;
      end
   end

   // write port: clearing sweep or training
   always_comb begin
      if (clear.active) begin
         wr_en    = 1'b1;
         wr_index = clear.count[HISTORY_BITS-1:0];
         wr_ctr   = CTR_ZERO;
      end else begin
         wr_en    = train.en;
         wr_index = s1_index;
         wr_ctr   = ctr_train(s1_ctr, train.taken);
      end
   end

   gbp_ram #(
      .WIDTH(CTR_BITS),
      .DEPTH(PHT_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_index),
      .wr_data(wr_ctr),
      .rd_addr(pht_index_of(rd_pc, ghr_in)),
      .rd_data(ram_rd_data)
   );

   // history and last write
   always_ff @(posedge clock) begin
      if (reset) begin
         ghr_ff       <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         ghr_ff       <= ghr_in;
         fwd_valid_ff <= wr_en;
      end
      fwd_index_ff <= wr_index;
      fwd_ctr_ff   <= wr_ctr;
   end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// tb: self-checking testbench for gshare_btb_branch_predictor. A class keeps its own copy of
// the btb, pattern counters and global history and predicts every result beat.
// Depends on gbp_pkg and the rtl of gshare_btb_branch_predictor.
`timescale 1ns / 1ps

module tb;
   import gbp_pkg::*;

   // expected next-pc results, worked out from a private copy of predictor state
   class prediction_board;
      bit           entry_valid [BTB_DEPTH];
      tag_type      entry_tag   [BTB_DEPTH];
      bit           entry_cond  [BTB_DEPTH];
      bit           entry_ind   [BTB_DEPTH];
      addr_type     entry_target[BTB_DEPTH];
      ctr_type      counters    [PHT_DEPTH];
      history_type  history;
      rsp_beat_type predictions [$];
      int unsigned  failures;

      function new();
         foreach (entry_valid[i]) entry_valid[i] = 1'b0;
         foreach (counters[i]) counters[i] = CTR_ZERO;
         history  = '0;
         failures = 0;
      endfunction

      function int outstanding();
         return predictions.size();
      endfunction

      // accepted request beat: queue a prediction or train the tables
      function void note_request(req_beat_type b);
         btb_index_type slot;
         tag_type       tag;
         pht_index_type row;
         bit            hit;
         rsp_beat_type  p;
         slot = btb_index_type'(b.pc >> 2);
         tag  = tag_type'(((b.pc >> (BTB_INDEX_BITS + 2)) << 2) | (b.pc & 64'd3));
         row  = pht_index_type'(b.pc >> 2) ^ history;
         hit  = entry_valid[slot] && (entry_tag[slot] == tag);
         if (b.req_type == REQ_PREDICT) begin
            p.btb_hit    = hit;
            p.pred_taken = 1'b0;
            p.next_pc    = b.pc + PC_STEP;
            if (hit) begin
               // an indirect hit is taken, but next pc falls through to pc + 4
               if (entry_ind[slot]) begin
                  p.pred_taken = 1'b1;
               end else if (!entry_cond[slot] || counters[row] >= CTR_TAKEN_MIN) begin
                  p.pred_taken = 1'b1;
                  p.next_pc    = entry_target[slot];
               end
            end
            predictions.push_back(p);
         end else begin
            // allocate on miss, even with the valid bit clear
            if (!hit) begin
               entry_valid[slot]  = b.entry_valid;
               entry_tag[slot]    = tag;
               entry_cond[slot]   = b.is_conditional;
               entry_ind[slot]    = b.is_indirect;
               entry_target[slot] = b.resolved_target;
            end
            // conditional: saturating counter and history shift
            if (b.is_conditional) begin
               if (b.was_taken && counters[row] != CTR_MAX)
                  counters[row] = counters[row] + CTR_STEP;
               else if (!b.was_taken && counters[row] != CTR_ZERO)
                  counters[row] = counters[row] - CTR_STEP;
               history = {history[HISTORY_BITS-2:0], b.was_taken};
            end
         end
      endfunction

      // accepted result beat against the oldest prediction
      function void check_prediction(rsp_beat_type got);
         rsp_beat_type want;
         if (predictions.size() == 0) begin
            failures++;
            $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
            return;
         end
         want = predictions.pop_front();
         if (got.btb_hit !== want.btb_hit) begin
            failures++;
            $display("%0t: btb_hit expected %0b actual %0b", $time,
                     want.btb_hit, got.btb_hit);
         end
         if (got.pred_taken !== want.pred_taken) begin
            failures++;
            $display("%0t: pred_taken expected %0b actual %0b", $time,
                     want.pred_taken, got.pred_taken);
         end
         if (got.next_pc !== want.next_pc) begin
            failures++;
            $display("%0t: next_pc expected %h actual %h", $time,
                     want.next_pc, got.next_pc);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_data;

   prediction_board board;
   bit              sender_quiet = 1'b0;
   bit              receiver_quiet = 1'b0;
   int unsigned     stall_left = 0;
   addr_type        pool[24];

   gshare_btb_branch_predictor DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check each accepted beat, then draw a stall
   always @(posedge clock) begin : receiver
      int unsigned hold;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         board.check_prediction(rsp_data);
         hold = receiver_quiet ? 0 : $urandom_range(0, 11);
         rsp_stall  <= (hold != 0);
         stall_left <= hold;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end
   end

   function automatic addr_type random_addr();
      return {$urandom, $urandom};
   endfunction

   // predict beat; the fields it does not use carry noise
   function automatic req_beat_type predict_beat(input addr_type pc);
      req_beat_type b;
      b.req_type        = REQ_PREDICT;
      b.pc              = pc;
      b.entry_valid     = 1'($urandom_range(0, 1));
      b.is_conditional  = 1'($urandom_range(0, 1));
      b.resolved_target = random_addr();
      b.was_taken       = 1'($urandom_range(0, 1));
      b.is_indirect     = 1'($urandom_range(0, 1));
      return b;
   endfunction

   function automatic req_beat_type update_beat(input addr_type pc, input logic valid,
                                                input logic cond, input logic ind,
                                                input logic taken, input addr_type target);
      req_beat_type b;
      b.req_type        = REQ_UPDATE;
      b.pc              = pc;
      b.entry_valid     = valid;
      b.is_conditional  = cond;
      b.resolved_target = target;
      b.was_taken       = taken;
      b.is_indirect     = ind;
      return b;
   endfunction

   // one request beat: random gap, then hold until accepted
   task automatic send_beat(input req_beat_type b);
      int unsigned gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_request(b);
   endtask

   // hold off the sender until every prediction has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // stimulus
   initial begin
      addr_type    pc_a, pc_a2, pc_b, pc_c, pc_d, tgt_c, pc_pick;
      int unsigned pick;
      board = new();
      // address pool: the last eight alias the first eight's btb slots
      for (int i = 0; i < 24; i++) begin
         pool[i] = random_addr();
         if (i % 4 != 0) pool[i][1:0] = 2'b00;
         if (i >= 16) pool[i][BTB_INDEX_BITS+1:2] = pool[i-16][BTB_INDEX_BITS+1:2];
      end
      pc_a  = 64'h8000_0000_0000_0040;
      pc_a2 = 64'h0000_0000_0001_0040;
      pc_b  = 64'hFFFF_FFFF_FFFF_FFFC;
      pc_c  = 64'h0000_0000_0000_0AB4;
      pc_d  = 64'h5555_5555_5555_5556;
      tgt_c = 64'h0000_7FFF_0000_1000;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // misses at the address extremes, including pc + 4 wrap
      send_beat(predict_beat('0));
      send_beat(predict_beat('1));
      // unconditional hit to the largest target
      send_beat(update_beat(pc_a, 1'b1, 1'b0, 1'b0, 1'b1, '1));
      send_beat(predict_beat(pc_a));
      // indirect hit at the top of memory: taken, next pc wraps
      send_beat(update_beat(pc_b, 1'b1, 1'b0, 1'b1, 1'b1, 64'h1234));
      send_beat(predict_beat(pc_b));
      // allocation with the valid bit clear stays a miss
      send_beat(update_beat(pc_d, 1'b0, 1'b0, 1'b0, 1'b0, random_addr()));
      send_beat(predict_beat(pc_d));
      // tag conflict replaces the entry
      send_beat(update_beat(pc_a2, 1'b1, 1'b0, 1'b0, 1'b0, 64'hAAAA_5555_AAAA_5554));
      send_beat(predict_beat(pc_a));
      send_beat(predict_beat(pc_a2));
      // counter held at zero, then history filled and counter driven to its top
      send_beat(update_beat(pc_c, 1'b1, 1'b1, 1'b0, 1'b0, tgt_c));
      for (int k = 0; k < 12; k++)
         send_beat(update_beat(pc_c, 1'b1, 1'b1, 1'b0, 1'b1, tgt_c));
      send_beat(predict_beat(pc_c));

      // random traffic, mostly on the pool so entries and counters get trained
      for (int n = 0; n < 625; n++) begin
         if (n % 40 == 0) begin
            sender_quiet   = ($urandom_range(0, 3) == 0);
            receiver_quiet = ($urandom_range(0, 3) == 0);
         end
         if (n == 300) drain();
         pick    = $urandom_range(0, 99);
         pc_pick = pool[$urandom_range(0, 23)];
         if (pick < 45)
            send_beat(predict_beat(pc_pick));
         else if (pick < 80)
            send_beat(update_beat(pc_pick, $urandom_range(0, 9) != 0,
                                  $urandom_range(0, 2) != 0, $urandom_range(0, 4) == 0,
                                  1'($urandom_range(0, 1)), random_addr()));
         else if (pick < 90)
            send_beat(predict_beat(random_addr()));
         else
            send_beat(update_beat(random_addr(), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), random_addr()));
      end

      // wait for the last predictions, then a little longer for strays
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (board.failures == 0 && board.outstanding() == 0)
         $display("** gshare_btb_branch_predictor: PASSED **");
      else
         $display("** gshare_btb_branch_predictor: FAILED **");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("** gshare_btb_branch_predictor: FAILED **");
      $finish;
   end

endmodule
